>>> hw/rtl/bxds_pkg.sv
package bxds_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_SCALE  = 16;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int SUM_W      = 16;
   localparam int AREA_W     = 9;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int DIV_STEPS  = SUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [1:0] REG_SCALE      = 2'd0;
   localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd2;
   localparam logic [1:0] REG_PIX_FMT    = 2'd3;

   localparam logic [1:0] FMT_8BPP  = 2'd0;
   localparam logic [1:0] FMT_24BPP = 2'd1;

   typedef struct packed {
      logic [3:0][7:0]    lanes;
      logic [COL_W-1:0]   col;
      logic               first;
      logic               emit;
      logic               last;
      logic [AREA_W-1:0]  area;
   } entry_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_ACC,
      B_DIV,
      B_HOLD
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic mem_rd;
      logic mem_wr;
      logic out_load;
   } back_ctl_type;

endpackage

>>> hw/rtl/bxds_front.sv
module bxds_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [12:0]          csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,
   input  logic                 q_full,
   output logic                 q_push,
   output bxds_pkg::entry_type  q_entry
);
   import bxds_pkg::*;

   logic [4:0]  scale_ff, scale_in;
   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [1:0]  fmt_ff, fmt_in;

   logic [12:0] src_col_ff, src_col_in;
   logic [12:0] src_row_ff, src_row_in;
   logic [3:0]  bco_ff, bco_in;
   logic [3:0]  bro_ff, bro_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [12:0] col_base_ff, col_base_in;
   logic [12:0] row_base_ff, row_base_in;

   logic [4:0]  s_eff;
   logic [12:0] w_eff, h_eff;
   logic [3:0]  s_m1;
   logic        col_used, row_used, col_last, row_last, bco_end, bro_end, accept;
   logic [14:0] col_end1, col_end2, row_end1, row_end2;
   logic [9:0]  area_full;

   always_comb begin
      s_eff = scale_ff;
      if (scale_ff == 5'd0) s_eff = 5'd1;
      if (scale_ff > 5'(MAX_SCALE)) s_eff = 5'(MAX_SCALE);
      w_eff = width_ff;
      if (width_ff == 13'd0) w_eff = 13'd1;
      if (width_ff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
      h_eff = (height_ff == 13'd0) ? 13'd1 : height_ff;
      s_m1 = 4'(s_eff - 5'd1);
      area_full = 10'(s_eff) * 10'(s_eff);
   end

   // a block is whole when its start plus s stays inside the image
   assign col_end1 = {2'b0, col_base_ff} + 15'(s_eff);
   assign col_end2 = col_end1 + 15'(s_eff);
   assign row_end1 = {2'b0, row_base_ff} + 15'(s_eff);
   assign row_end2 = row_end1 + 15'(s_eff);
   assign col_used = col_end1 <= {2'b0, w_eff};
   assign row_used = row_end1 <= {2'b0, h_eff};
   assign col_last = col_end2 > {2'b0, w_eff};
   assign row_last = row_end2 > {2'b0, h_eff};
   assign bco_end  = bco_ff == s_m1;
   assign bro_end  = bro_ff == s_m1;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && col_used && row_used;

   always_comb begin
      q_entry.lanes[0] = req_tdata[7:0];
      q_entry.lanes[1] = (fmt_ff != FMT_8BPP) ? req_tdata[15:8] : 8'd0;
      q_entry.lanes[2] = (fmt_ff != FMT_8BPP) ? req_tdata[23:16] : 8'd0;
      q_entry.lanes[3] = (fmt_ff != FMT_8BPP && fmt_ff != FMT_24BPP) ?
                         req_tdata[31:24] : 8'd0;
      q_entry.col   = out_col_ff;
      q_entry.first = (bco_ff == 4'd0) && (bro_ff == 4'd0);
      q_entry.emit  = bco_end && bro_end;
      q_entry.last  = bco_end && bro_end && col_last && row_last;
      q_entry.area  = area_full[AREA_W-1:0];
   end

   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      fmt_in    = fmt_ff;
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      bco_in      = bco_ff;
      bro_in      = bro_ff;
      out_col_in  = out_col_ff;
      col_base_in = col_base_ff;
      row_base_in = row_base_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_SCALE:      scale_in  = csr_wdata[4:0];
            REG_SRC_WIDTH:  width_in  = csr_wdata;
            REG_SRC_HEIGHT: height_in = csr_wdata;
            REG_PIX_FMT:    fmt_in    = csr_wdata[1:0];
            default:        ;
         endcase
         src_col_in  = '0;
         src_row_in  = '0;
         bco_in      = '0;
         bro_in      = '0;
         out_col_in  = '0;
         col_base_in = '0;
         row_base_in = '0;
      end else if (accept) begin
         if (col_used) begin
            bco_in = bco_ff + 4'd1;
            if (bco_end) begin
               bco_in      = '0;
               out_col_in  = out_col_ff + 1'b1;
               col_base_in = col_end1[12:0];
            end
         end
         src_col_in = src_col_ff + 13'd1;
         if ({1'b0, src_col_ff} + 14'd1 >= {1'b0, w_eff}) begin
            src_col_in  = '0;
            bco_in      = '0;
            out_col_in  = '0;
            col_base_in = '0;
            if (row_used) begin
               bro_in = bro_ff + 4'd1;
               if (bro_end) begin
                  bro_in      = '0;
                  row_base_in = row_end1[12:0];
               end
            end
            src_row_in = src_row_ff + 13'd1;
            if ({1'b0, src_row_ff} + 14'd1 >= {1'b0, h_eff}) begin
               src_row_in  = '0;
               bro_in      = '0;
               row_base_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= 5'd1;
         width_ff    <= 13'd1;
         height_ff   <= 13'd1;
         fmt_ff      <= FMT_8BPP;
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         bco_ff      <= '0;
         bro_ff      <= '0;
         out_col_ff  <= '0;
         col_base_ff <= '0;
         row_base_ff <= '0;
      end else begin
         scale_ff    <= scale_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         fmt_ff      <= fmt_in;
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         bco_ff      <= bco_in;
         bro_ff      <= bro_in;
         out_col_ff  <= out_col_in;
         col_base_ff <= col_base_in;
         row_base_ff <= row_base_in;
      end
   end

endmodule

>>> hw/rtl/bxds_queue.sv
module bxds_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bxds_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 nonempty,
   output bxds_pkg::entry_type  head
);
   import bxds_pkg::*;

   entry_type          slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;

   assign full     = count_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign nonempty = count_ff != '0;
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("item pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> nonempty)
      else $error("item popped from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_PTR_W+1)'(Q_DEPTH))
      else $error("queue count out of range");

endmodule

>>> hw/rtl/bxds_back.sv
module bxds_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_nonempty,
   input  bxds_pkg::entry_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tlast
);
   import bxds_pkg::*;

   back_state_type state_ff, state_in;
   back_ctl_type   ctl;

   logic [4*SUM_W-1:0] mem [MAX_WIDTH];
   logic [4*SUM_W-1:0] rd_data_ff;
   entry_type          cur_ff;

   logic [3:0][SUM_W-1:0] sum;
   logic [3:0][SUM_W-1:0] quo_ff, quo_in;
   logic [3:0][SUM_W:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  div_done;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff;
   logic        out_last_ff;

   assign div_done = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (q_nonempty) state_in = B_READ;
         B_READ: state_in = B_ACC;
         B_ACC:  state_in = cur_ff.emit ? B_DIV : B_IDLE;
         B_DIV:  if (div_done) state_in = B_HOLD;
         B_HOLD: if (!out_valid_ff) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         B_IDLE: ctl.pop = q_nonempty;
         B_READ: ctl.mem_rd = 1'b1;
         B_ACC:  ctl.mem_wr = 1'b1;
         B_HOLD: ctl.out_load = !out_valid_ff;
         default: ;
      endcase
   end

   assign q_pop = ctl.pop;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum[k] = cur_ff.first ? {8'd0, cur_ff.lanes[k]} :
                  rd_data_ff[k*SUM_W +: SUM_W] + {8'd0, cur_ff.lanes[k]};
      end
   end

   // restoring divide, one quotient bit per lane per cycle
   always_comb begin
      logic [SUM_W:0] trial;
      trial  = '0;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (ctl.mem_wr) begin
         quo_in = sum;
         rem_in = '0;
         cnt_in = '0;
      end else if (state_ff == B_DIV) begin
         cnt_in = cnt_ff + 1'b1;
         for (int k = 0; k < 4; k++) begin
            trial = {rem_ff[k][SUM_W-1:0], quo_ff[k][SUM_W-1]};
            if (trial >= (SUM_W+1)'(cur_ff.area)) begin
               rem_in[k] = trial - (SUM_W+1)'(cur_ff.area);
               quo_in[k] = {quo_ff[k][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[k] = trial;
               quo_in[k] = {quo_ff[k][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (ctl.out_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (ctl.pop) cur_ff <= q_head;
      if (ctl.mem_rd) rd_data_ff <= mem[cur_ff.col];
      if (ctl.mem_wr) mem[cur_ff.col] <= sum;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (ctl.out_load) begin
         out_data_ff <= {quo_ff[3][7:0], quo_ff[2][7:0], quo_ff[1][7:0], quo_ff[0][7:0]};
         out_last_ff <= cur_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> !out_valid_ff)
      else $error("result overwritten before taken");
   a_div_follows_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_ACC && cur_ff.emit) |=> state_ff == B_DIV)
      else $error("division did not start");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == B_READ)
      else $error("pop without read");

endmodule

>>> hw/rtl/box_average_image_downscaler_top.sv
// channel   ports                               payload
// req       req_tvalid/req_tready/req_tdata     byte0..byte3
// rsp       rsp_tvalid/rsp_tready/rsp_tdata     out_byte0..out_byte3, tlast = frame_end
// csr       csr_we/csr_addr/csr_wdata           scale, src_width, src_height, pixel_format
// An item in a whole block passes through pop, sum read and write in the back end;
// an item that closes a block then runs the divider and loads the result.
// Items outside whole blocks are accepted but never reach the back end.
// The front fills a 4-entry queue while the back end works or stalls, until it is full.
// Synchronous reset clears counters and control; the column sums are not cleared.
module box_average_image_downscaler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // byte0, byte1, byte2, byte3
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_byte0, out_byte1, out_byte2, out_byte3
   output logic        rsp_tlast
);
   import bxds_pkg::*;

   entry_type push_entry, head;
   logic      q_full, q_push, q_pop, q_nonempty;

   bxds_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .q_full(q_full), .q_push(q_push), .q_entry(push_entry)
   );

   bxds_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_entry(push_entry), .full(q_full),
      .pop(q_pop), .nonempty(q_nonempty), .head(head)
   );

   bxds_back u_back (
      .clock(clock), .reset(reset),
      .q_nonempty(q_nonempty), .q_head(head), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

endmodule

>>> sim/box_average_checker.sv
module box_average_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // byte0, byte1, byte2, byte3
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // out_byte0, out_byte1, out_byte2, out_byte3
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   import bxds_pkg::*;

   typedef struct {
      logic [7:0] lane [4];
      logic       frame_end;
   } avg_pixel_type;

   avg_pixel_type avg_q [$];
   logic [15:0]   col_sum [MAX_WIDTH][4];

   logic [4:0]  cfg_scale;
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   logic [1:0]  cfg_fmt;

   int unsigned src_col, src_row, blk_col, blk_row, out_col;

   function automatic void restart_frame();
      src_col = 0;
      src_row = 0;
      blk_col = 0;
      blk_row = 0;
      out_col = 0;
   endfunction

   // one source pixel through the predictor; may push one averaged pixel
   function automatic void accumulate_pixel(input logic [31:0] px);
      int unsigned   s, w, h, n_lanes, used_w, used_h, area;
      logic          first;
      logic [7:0]    v;
      avg_pixel_type p;
      s = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_SCALE) ? MAX_SCALE : cfg_scale;
      w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = (cfg_height == 0) ? 1 : cfg_height;
      n_lanes = (cfg_fmt == FMT_8BPP) ? 1 : (cfg_fmt == FMT_24BPP) ? 3 : 4;
      used_w = (w / s) * s;
      used_h = (h / s) * s;
      if (src_col < used_w && src_row < used_h && out_col < MAX_WIDTH) begin
         first = (blk_row == 0 && blk_col == 0);
         for (int k = 0; k < 4; k++) begin
            v = (k < n_lanes) ? px[8*k +: 8] : 8'd0;
            col_sum[out_col][k] = first ? 16'(v) : col_sum[out_col][k] + 16'(v);
         end
         if (blk_row == s - 1 && blk_col == s - 1) begin
            area = s * s;
            for (int k = 0; k < 4; k++)
               p.lane[k] = (k < n_lanes) ? 8'(col_sum[out_col][k] / area) : 8'd0;
            p.frame_end = (src_col == used_w - 1 && src_row == used_h - 1);
            avg_q.push_back(p);
         end
      end
      if (src_col < used_w) begin
         blk_col++;
         if (blk_col >= s) begin
            blk_col = 0;
            out_col++;
         end
      end
      src_col++;
      if (src_col >= w) begin
         src_col = 0;
         blk_col = 0;
         out_col = 0;
         if (src_row < used_h) begin
            blk_row++;
            if (blk_row >= s) blk_row = 0;
         end
         src_row++;
         if (src_row >= h) begin
            src_row = 0;
            blk_row = 0;
         end
      end
   endfunction

   always @(posedge clock) begin
      avg_pixel_type exp_px;
      logic          bad;
      if (reset) begin
         cfg_scale  = 5'd1;
         cfg_width  = 13'd1;
         cfg_height = 13'd1;
         cfg_fmt    = FMT_8BPP;
         restart_frame();
         avg_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (avg_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected output pixel data=%h last=%b", rsp_tdata, rsp_tlast);
            end else begin
               exp_px = avg_q.pop_front();
               bad = (rsp_tlast !== exp_px.frame_end);
               for (int k = 0; k < 4; k++)
                  if (rsp_tdata[8*k +: 8] !== exp_px.lane[k]) bad = 1'b1;
               if (bad) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("pixel mismatch: exp %h %h %h %h last=%b, got %h last=%b",
                              exp_px.lane[3], exp_px.lane[2], exp_px.lane[1],
                              exp_px.lane[0], exp_px.frame_end, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) accumulate_pixel(req_tdata);
         if (csr_we) begin
            case (csr_addr)
               REG_SCALE:      cfg_scale  = csr_wdata[4:0];
               REG_SRC_WIDTH:  cfg_width  = csr_wdata;
               REG_SRC_HEIGHT: cfg_height = csr_wdata;
               REG_PIX_FMT:    cfg_fmt    = csr_wdata[1:0];
               default:        ;
            endcase
            restart_frame();
         end
      end
      pending = avg_q.size();
   end

endmodule

>>> sim/tb_box_average_image_downscaler_top.sv
module tb_box_average_image_downscaler_top;
   import bxds_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 420;

   localparam int KIND_ZERO   = 0;
   localparam int KIND_ONES   = 1;
   localparam int KIND_RANDOM = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [12:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // byte0, byte1, byte2, byte3
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // out_byte0, out_byte1, out_byte2, out_byte3
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   logic        no_gaps = 1'b0;

   always #10 clock = ~clock;

   box_average_image_downscaler_top u_top (.*);

   box_average_checker u_chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // output side stall pattern
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_frame(input int scale, input int width, input int height,
                            input int fmt);
      drain();
      csr_we <= 1'b1;
      csr_addr <= REG_SCALE;      csr_wdata <= 13'(scale);  @(negedge clock);
      csr_addr <= REG_SRC_WIDTH;  csr_wdata <= 13'(width);  @(negedge clock);
      csr_addr <= REG_SRC_HEIGHT; csr_wdata <= 13'(height); @(negedge clock);
      csr_addr <= REG_PIX_FMT;    csr_wdata <= 13'(fmt);    @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [31:0] px);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= px;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_frame(input int count, input int kind);
      for (int i = 0; i < count; i++)
         case (kind)
            KIND_ZERO: send_pixel(32'h0);
            KIND_ONES: send_pixel(32'hFFFF_FFFF);
            default:   send_pixel($urandom);
         endcase
   endtask

   initial begin
      int s, w, h, n, pause_at;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: flat frames at the scale extreme, random frames at scale 2, all formats
      set_frame(16, 16, 16, 3); send_frame(256, KIND_ONES);
      set_frame(16, 16, 16, 0); send_frame(256, KIND_ZERO);
      set_frame(2, 4, 4, 1);    send_frame(16, KIND_RANDOM);
      set_frame(2, 4, 4, 2);    send_frame(16, KIND_RANDOM);
      // scale zero and oversized scale
      set_frame(0, 3, 2, 1);    send_frame(6, KIND_RANDOM);
      set_frame(31, 17, 17, 2); send_frame(289, KIND_RANDOM);
      // zero sizes, image smaller than one block
      set_frame(1, 0, 0, 2);    send_frame(3, KIND_RANDOM);
      set_frame(4, 3, 9, 2);    send_frame(27, KIND_RANDOM);
      // oversized width, tall height
      set_frame(1, 8191, 8191, 0); send_frame(20, KIND_RANDOM);

      // random frames
      n = 0;
      pause_at = $urandom_range(50, 300);
      while (n < RANDOM_ITEMS) begin
         s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
         w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
         h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
         if (s > 4) begin
            w = $urandom_range(s, s + 4);
            h = $urandom_range(s, s + 2);
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         set_frame(s, w, h, $urandom_range(0, 3));
         w = (w == 0) ? 1 : w;
         h = (h == 0) ? 1 : h;
         for (int i = w * h * $urandom_range(1, 2) + $urandom_range(0, 5);
              i > 0 && n < RANDOM_ITEMS; i--) begin
            send_pixel($urandom);
            n++;
            if (n == pause_at) begin
               req_tvalid <= 1'b0;
               while (pending != 0) @(negedge clock);
            end
         end
      end

      drain();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
